// ===== rtl/cursor_query_escape_filter_core_defines.svh =====
// assertion macros for the cursor query escape filter
`ifndef CURSOR_QUERY_ESCAPE_FILTER_CORE_DEFINES_SVH
`define CURSOR_QUERY_ESCAPE_FILTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CQEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CQEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cqef_pkg.sv =====
// types, constants and helpers shared by the cursor query escape filter
package cqef_pkg;

	localparam int SEQ_LEN = 4;
	localparam int MATCH_W = $clog2(SEQ_LEN);
	localparam logic [7:0] LINE_FEED = 8'h0A;
	localparam int DEFAULT_QUEUE_DEPTH = 2;

	localparam logic [7:0] QUERY_BYTES [SEQ_LEN] = '{8'h1B, 8'h5B, 8'h36, 8'h6E};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_dump;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       at_line_start;
		logic       last_of_run;
	} out_item_t;

	// one queued job: replay held query bytes, then optionally one stream byte
	typedef struct packed {
		logic [MATCH_W-1:0] held;
		logic               has_byte;
		logic [7:0]         data;
	} op_t;

	function automatic logic [7:0] query_byte(input logic [MATCH_W-1:0] idx);
		query_byte = QUERY_BYTES[idx];
	endfunction

endpackage

// ===== rtl/cqef_front.sv =====
// front end: accepts stream items, tracks the partial query match, issues jobs
module cqef_front import cqef_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     item_valid,
	output logic     item_ready,
	output op_t      push_op,
	output logic     push_valid,
	input  logic     push_ready
);

	logic [MATCH_W-1:0] match_count_q;
	logic               accept;
	logic               advance;

	// the item is taken even when it causes no job, so wait for queue space
	assign item_ready = push_ready;
	assign accept = item_valid && item_ready;

	// with nothing held this is the test for ESC, which is the only way to start
	assign advance = !item.end_of_dump && (item.in_byte == query_byte(match_count_q));

	always_comb begin
		push_op.held = match_count_q;
		push_op.has_byte = !item.end_of_dump;
		push_op.data = item.in_byte;
		push_valid = 1'b0;
		if (accept && !advance) begin
			push_valid = !item.end_of_dump || (match_count_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q <= '0;
		end else if (accept) begin
			// completing the query wraps the count back to zero and drops it
			if (advance) begin
				match_count_q <= match_count_q + MATCH_W'(1);
			end else begin
				match_count_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/cqef_queue.sv =====
// small job queue between the front and back ends
module cqef_queue import cqef_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  op_t  push_op,
	input  logic push_valid,
	output logic push_ready,
	output op_t  pop_op,
	output logic pop_valid,
	input  logic pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t            slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_op = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/cqef_back.sv =====
// back end: plays out each job one byte per cycle into the output register while result_ready allows
`include "cursor_query_escape_filter_core_defines.svh"

module cqef_back import cqef_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  op_t       pop_op,
	input  logic      pop_valid,
	output logic      pop_ready,
	output out_item_t result,
	output logic      result_valid,
	input  logic      result_ready
);

	op_t                work_op_q;
	logic               work_valid_q;
	logic [MATCH_W-1:0] idx_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic               can_load;
	logic               step;
	logic               emit_held;
	logic               last;
	logic [7:0]         next_byte;
	logic               done;

	assign can_load = !out_valid_q || result_ready;
	assign step = can_load && work_valid_q;
	assign emit_held = (idx_q < work_op_q.held);

	always_comb begin
		if (emit_held) begin
			next_byte = query_byte(idx_q);
			last = ((idx_q + MATCH_W'(1)) == work_op_q.held) && !work_op_q.has_byte;
		end else begin
			next_byte = work_op_q.data;
			last = 1'b1;
		end
	end

	assign done = step && last;
	// refill the job register in the same cycle its last byte leaves
	assign pop_ready = !work_valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				work_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (done) begin
				work_valid_q <= 1'b0;
			end else if (step) begin
				idx_q <= idx_q + MATCH_W'(1);
			end
			if (can_load) begin
				out_valid_q <= work_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			work_op_q <= pop_op;
		end
		if (step) begin
			out_q.out_byte <= next_byte;
			out_q.at_line_start <= (next_byte == LINE_FEED);
			out_q.last_of_run <= last;
		end
	end

	assign result = out_q;
	assign result_valid = out_valid_q;

	`CQEF_ASSERT_NOW(a_idx_in_range, work_valid_q, idx_q <= work_op_q.held, "replay index past held bytes")
	`CQEF_ASSERT_NOW(a_job_not_empty, work_valid_q, (work_op_q.held != '0) || work_op_q.has_byte, "empty job reached back end")
	`CQEF_ASSERT_NOW(a_run_continues, out_valid_q && !out_q.last_of_run, work_valid_q, "run cut short before its last byte")
	`CQEF_ASSERT_NEXT(a_done_clears, done && !pop_valid, !work_valid_q, "job register not released after last byte")

endmodule

// ===== rtl/cursor_query_escape_filter_core.sv =====
// Cursor query escape filter: drops complete ESC [ 6 n queries from a byte stream (a byte that
// breaks a partial match never starts one) and passes all other bytes, flagging line feeds and
// the last byte each transaction causes. Input is taken at one transaction per cycle while the
// job queue has room; breaking a partial match of k held bytes emits k+1 bytes, played out one
// byte per cycle unless the output is held. The QUEUE_DEPTH-entry job queue lets input continue
// during such a replay. An accepted byte passes a queue slot, the job register and the output
// register in turn. An end-of-dump transaction flushes held bytes, or emits nothing.
module cursor_query_escape_filter_core import cqef_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  logic      item_valid,
	output logic      item_ready,
	output out_item_t result,
	output logic      result_valid,
	input  logic      result_ready
);

	op_t  push_op;
	logic push_valid;
	logic push_ready;
	op_t  pop_op;
	logic pop_valid;
	logic pop_ready;

	cqef_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.push_op    (push_op),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	cqef_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (push_op),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_op     (pop_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	cqef_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_op       (pop_op),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

// ===== tb/sv/tb_cursor_query_escape_filter_core.sv =====
// self-checking testbench for the cursor query escape filter core
module tb_cursor_query_escape_filter_core;
	import cqef_pkg::*;

	localparam logic [7:0] ESC_BYTE = QUERY_BYTES[0];
	localparam logic [7:0] BRACKET_BYTE = QUERY_BYTES[1];
	localparam logic [7:0] SIX_BYTE = QUERY_BYTES[2];
	localparam logic [7:0] REPORT_BYTE = QUERY_BYTES[3];
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS = 125;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	in_item_t  item = '0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	out_item_t result;
	logic      result_valid;
	logic      result_ready = 1'b0;

	// predictor state
	logic [MATCH_W-1:0] held_count = '0;
	out_item_t          expected_bytes [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	cursor_query_escape_filter_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// works out the bytes one accepted transaction releases
	task automatic predict_filter(input in_item_t it);
		logic [7:0] emitted [$];
		emitted = {};
		if (it.end_of_dump) begin
			for (int i = 0; i < held_count; i++)
				emitted.push_back(QUERY_BYTES[MATCH_W'(i)]);
			held_count = '0;
		end else if (held_count != 0 || it.in_byte == ESC_BYTE) begin
			if (it.in_byte == QUERY_BYTES[held_count]) begin
				held_count = (held_count == SEQ_LEN - 1) ? '0 : held_count + 1'b1;
			end else begin
				// breaking byte follows the held bytes and never restarts a match
				for (int i = 0; i < held_count; i++)
					emitted.push_back(QUERY_BYTES[MATCH_W'(i)]);
				emitted.push_back(it.in_byte);
				held_count = '0;
			end
		end else begin
			emitted.push_back(it.in_byte);
		end
		for (int i = 0; i < emitted.size(); i++)
			expected_bytes.push_back('{out_byte: emitted[i],
				at_line_start: (emitted[i] == LINE_FEED),
				last_of_run: (i == emitted.size() - 1)});
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %p", $time, got);
			mismatch_count++;
		end else begin
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h actual %02h",
					$time, want.out_byte, got.out_byte);
				mismatch_count++;
			end
			if (got.at_line_start !== want.at_line_start) begin
				$display("%0t: at_line_start expected %b actual %b",
					$time, want.at_line_start, got.at_line_start);
				mismatch_count++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$display("%0t: last_of_run expected %b actual %b",
					$time, want.last_of_run, got.last_of_run);
				mismatch_count++;
			end
		end
	endtask

	// monitor both channels, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				predict_filter(item);
			if (result_valid && result_ready)
				check_result(result);
		end
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		item <= it;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!item_ready);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{in_byte: b, end_of_dump: 1'b0});
	endtask

	task automatic send_flush(input logic [7:0] ignored);
		send_item('{in_byte: ignored, end_of_dump: 1'b1});
	endtask

	// hold off the sender until every expected byte is out
	task automatic wait_drain();
		item_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return LINE_FEED;
		if (roll < 3)
			return QUERY_BYTES[MATCH_W'($urandom_range(SEQ_LEN - 1))];
		return 8'($urandom_range(255));
	endfunction

	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(LINE_FEED);
	endtask

	task automatic test_query_removal();
		send_byte(ESC_BYTE);
		send_byte(BRACKET_BYTE);
		send_byte(SIX_BYTE);
		send_byte(REPORT_BYTE);
	endtask

	task automatic test_broken_match();
		send_byte(ESC_BYTE);
		send_byte(8'h41);
		// an escape that breaks a match is passed on, not held
		send_byte(ESC_BYTE);
		send_byte(BRACKET_BYTE);
		send_byte(ESC_BYTE);
		send_byte(ESC_BYTE);
		send_byte(BRACKET_BYTE);
		send_byte(SIX_BYTE);
		send_byte(LINE_FEED);
	endtask

	task automatic test_end_of_dump();
		send_flush(8'hFF);
		send_flush(ESC_BYTE);
		send_byte(ESC_BYTE);
		send_byte(BRACKET_BYTE);
		send_byte(SIX_BYTE);
		send_flush(8'h00);
		send_byte(ESC_BYTE);
		send_flush(REPORT_BYTE);
	endtask

	// mostly query prefixes with random endings, the rest noise and flushes
	task automatic test_random_traffic(input int n_items);
		int sent;
		int roll;
		int depth;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 65) begin
				depth = (roll < 30) ? SEQ_LEN : $urandom_range(1, SEQ_LEN - 1);
				for (int i = 0; i < depth; i++)
					send_byte(QUERY_BYTES[MATCH_W'(i)]);
				sent += depth;
				if (depth < SEQ_LEN) begin
					if ($urandom_range(3) == 0)
						send_flush(8'($urandom_range(255)));
					else
						send_byte(pick_byte());
					sent++;
				end
			end else if (roll < 72) begin
				send_flush(8'($urandom_range(255)));
				sent++;
			end else begin
				send_byte(pick_byte());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 74;
		test_plain_bytes();
		test_query_removal();
		test_broken_match();
		test_end_of_dump();
		test_random_traffic(RANDOM_ITEMS);
		wait_drain();

		send_idle_pct = 74;
		recv_idle_pct = 27;
		test_random_traffic(RANDOM_ITEMS);
		wait_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(RANDOM_ITEMS);
		wait_drain();

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
